// ----- design/hns_pkg.sv -----
// ----------------------------------------------------------------------------
// hns_pkg
// Shared types and constants for the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package hns_pkg;

	// size counter width, default
	localparam int SIZE_BITS_DEF = 24;
	// width of the unit_size field on the result channel
	localparam int SIZE_OUT_W    = 24;

	// at most this many results leave for one input byte
	localparam int MAX_RES    = 4;
	localparam int RES_IDX_W  = $clog2(MAX_RES);
	localparam int RES_CNT_W  = $clog2(MAX_RES + 1);

	localparam logic [7:0] ZERO_BYTE  = 8'h00;
	localparam logic [7:0] START_BYTE = 8'h01;
	localparam logic [4:0] TYPE_MASK  = 5'h1F;

	localparam logic [4:0] NAL_IDR = 5'd5;
	localparam logic [4:0] NAL_SPS = 5'd7;
	localparam logic [4:0] NAL_PPS = 5'd8;

	typedef enum logic [1:0] {
		DISP_FRAME = 2'd0,
		DISP_PARAM = 2'd1,
		DISP_DROP  = 2'd2
	} disp_t;

	// parser state, apart from the size counter
	typedef struct packed {
		logic [1:0] zero_hold;
		logic       inside_unit;
		logic       header_pending;
		logic [4:0] held_type;
		disp_t      held_disposition;
		logic       sps_seen;
		logic       pps_seen;
		logic       idr_seen;
		logic [7:0] pend_byte;
		logic       pend_valid;
	} hns_ctx_t;

	typedef struct packed {
		logic [7:0]            payload_byte;
		logic                  unit_first;
		logic                  unit_last;
		logic [4:0]            unit_type;
		disp_t                 disposition;
		logic [SIZE_OUT_W-1:0] unit_size;
	} hns_res_t;

endpackage

`default_nettype wire

// ----- design/hns_if.sv -----
// ----------------------------------------------------------------------------
// hns_if
// Valid/ready channels: byte stream in, NAL payload results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hns_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       buffer_end;

	modport source (output valid, output data_byte, output buffer_end, input ready);
	modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface hns_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        unit_first;
	logic        unit_last;
	logic [4:0]  unit_type;
	logic [1:0]  disposition;
	logic [23:0] unit_size;

	modport source (output valid, output payload_byte, output unit_first, output unit_last,
		output unit_type, output disposition, output unit_size, input ready);
	modport sink   (input valid, input payload_byte, input unit_first, input unit_last,
		input unit_type, input disposition, input unit_size, output ready);
endinterface

`default_nettype wire

// ----- design/hns_step.sv -----
// ----------------------------------------------------------------------------
// hns_step
// Next-state and result logic for one stream byte: start code detection,
// zero holding, header decode and payload emission.
// ----------------------------------------------------------------------------
`default_nettype none

module hns_step #(
	parameter int SIZE_BITS = hns_pkg::SIZE_BITS_DEF
) (
	input  logic [7:0]                                  data_byte,
	input  logic                                        buffer_end,
	input  logic                                        record_enable,
	input  hns_pkg::hns_ctx_t                           ctx_cur,
	input  logic [SIZE_BITS-1:0]                        cnt_cur,
	output hns_pkg::hns_ctx_t                           ctx_nxt,
	output logic [SIZE_BITS-1:0]                        cnt_nxt,
	output hns_pkg::hns_res_t [hns_pkg::MAX_RES-1:0]    res,
	output logic [hns_pkg::RES_CNT_W-1:0]               res_n
);
	import hns_pkg::*;

	localparam logic [SIZE_BITS-1:0] CNT_MAX = '1;

	function automatic void emit(input logic [7:0] b, input logic last, input hns_ctx_t c,
		inout logic [SIZE_BITS-1:0] n, inout hns_res_t [MAX_RES-1:0] r,
		inout logic [RES_CNT_W-1:0] k);
		hns_res_t e;
		e.payload_byte = b;
		e.unit_first   = (n == '0);
		if (n != CNT_MAX)
			n = n + 1'b1;
		e.unit_last    = last;
		e.unit_type    = c.held_type;
		e.disposition  = c.held_disposition;
		e.unit_size    = last ? SIZE_OUT_W'(n) : '0;
		r[k[RES_IDX_W-1:0]] = e;
		k = k + 1'b1;
	endfunction

	function automatic void decide(input logic [7:0] header, input logic rec,
		inout hns_ctx_t c);
		logic [4:0] t;
		disp_t      d;
		t = header[4:0] & TYPE_MASK;
		d = DISP_DROP;
		c.held_type = t;
		if (rec) begin
			if (t == NAL_SPS) begin
				d = DISP_PARAM;
				c.sps_seen = 1'b1;
			end else if (t == NAL_PPS) begin
				d = DISP_PARAM;
				c.pps_seen = 1'b1;
			end else if (t == NAL_IDR) begin
				if (c.sps_seen && c.pps_seen) begin
					d = DISP_FRAME;
					c.idr_seen = 1'b1;
				end
			end else if (c.idr_seen && c.sps_seen && c.pps_seen) begin
				d = DISP_FRAME;
			end
		end
		c.held_disposition = d;
	endfunction

	// payload runs one byte late so the final byte can carry the last mark
	function automatic void commit(input logic [7:0] b, input logic rec, inout hns_ctx_t c,
		inout logic [SIZE_BITS-1:0] n, inout hns_res_t [MAX_RES-1:0] r,
		inout logic [RES_CNT_W-1:0] k);
		if (c.inside_unit) begin
			if (c.header_pending) begin
				decide(b, rec, c);
				c.header_pending = 1'b0;
			end
			if (c.pend_valid)
				emit(c.pend_byte, 1'b0, c, n, r, k);
			c.pend_byte  = b;
			c.pend_valid = 1'b1;
		end
	endfunction

	function automatic void close_unit(inout hns_ctx_t c, inout logic [SIZE_BITS-1:0] n,
		inout hns_res_t [MAX_RES-1:0] r, inout logic [RES_CNT_W-1:0] k);
		if (c.inside_unit && c.pend_valid)
			emit(c.pend_byte, 1'b1, c, n, r, k);
		c.inside_unit    = 1'b0;
		c.header_pending = 1'b0;
		c.pend_valid     = 1'b0;
	endfunction

	always_comb begin : p_step
		hns_ctx_t                c;
		logic [SIZE_BITS-1:0]    n;
		hns_res_t [MAX_RES-1:0]  r;
		logic [RES_CNT_W-1:0]    k;
		c = ctx_cur;
		n = cnt_cur;
		r = '0;
		k = '0;

		if (data_byte == ZERO_BYTE) begin
			// third zero cannot be payload: it ends the unit
			if (c.zero_hold == 2'd2) begin
				close_unit(c, n, r, k);
				c.zero_hold = 2'd3;
			end else if (c.zero_hold < 2'd2) begin
				c.zero_hold = c.zero_hold + 2'd1;
			end
		end else if (data_byte == START_BYTE && c.zero_hold >= 2'd2) begin
			close_unit(c, n, r, k);
			c.inside_unit    = 1'b1;
			c.header_pending = 1'b1;
			c.pend_valid     = 1'b0;
			c.zero_hold      = 2'd0;
			n                = '0;
		end else begin
			// held zeros were payload after all
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < c.zero_hold)
					commit(ZERO_BYTE, record_enable, c, n, r, k);
			end
			commit(data_byte, record_enable, c, n, r, k);
			c.zero_hold = 2'd0;
		end

		if (buffer_end) begin
			if (c.zero_hold != 2'd3) begin
				for (int i = 0; i < 2; i++) begin
					if (2'(i) < c.zero_hold)
						commit(ZERO_BYTE, record_enable, c, n, r, k);
				end
			end
			close_unit(c, n, r, k);
			c.zero_hold = 2'd0;
		end

		ctx_nxt = c;
		cnt_nxt = n;
		res     = r;
		res_n   = k;
	end

endmodule

`default_nettype wire

// ----- design/hns_out_buf.sv -----
// ----------------------------------------------------------------------------
// hns_out_buf
// Result register holding the results of one byte, drained one per cycle while nal.ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module hns_out_buf (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     load,
	input  hns_pkg::hns_res_t [hns_pkg::MAX_RES-1:0] load_res,
	input  logic [hns_pkg::RES_CNT_W-1:0]            load_n,
	output logic                                     free,
	hns_out_if.source                                nal
);
	import hns_pkg::*;

	hns_res_t [MAX_RES-1:0] res_q;
	logic [RES_CNT_W-1:0]   n_q;
	logic [RES_CNT_W-1:0]   ptr_q;
	logic                   fire;
	hns_res_t               cur;

	assign nal.valid = (ptr_q != n_q);
	assign fire      = nal.valid && nal.ready;
	// empty now, or emptied by the request taken this cycle
	assign free      = !nal.valid || (fire && (ptr_q + 1'b1 == n_q));

	assign cur              = res_q[ptr_q[RES_IDX_W-1:0]];
	assign nal.payload_byte = cur.payload_byte;
	assign nal.unit_first   = cur.unit_first;
	assign nal.unit_last    = cur.unit_last;
	assign nal.unit_type    = cur.unit_type;
	assign nal.disposition  = cur.disposition;
	assign nal.unit_size    = cur.unit_size;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			ptr_q <= '0;
		end else if (load) begin
			n_q   <= load_n;
			ptr_q <= '0;
		end else if (fire) begin
			ptr_q <= ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= load_res;
	end

endmodule

`default_nettype wire

// ----- design/h264_annexb_nal_splitter.sv -----
// Flow: a byte taken on stream is registered in the input stage; its results load
// into the result register once it is free and drive nal from there. One byte per
// cycle while each byte yields at most one result and nal is ready; a byte with more
// results (up to 4) holds the input while the result register hands them out one per cycle.
// Reset: arst_n clears all parser state, the seen flags and record_enable.
`default_nettype none

// ----------------------------------------------------------------------------
// h264_annexb_nal_splitter
// Splits an Annex B byte stream into NAL unit payloads with disposition.
// ----------------------------------------------------------------------------
module h264_annexb_nal_splitter #(
	parameter int SIZE_BITS = hns_pkg::SIZE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	hns_in_if.sink    stream,
	hns_out_if.source nal
);
	import hns_pkg::*;

	logic                   valid_s1;
	logic [7:0]             data_byte_s1;
	logic                   buffer_end_s1;
	logic                   rec_q;
	hns_ctx_t               ctx_q;
	hns_ctx_t               ctx_d;
	logic [SIZE_BITS-1:0]   cnt_q;
	hns_ctx_t               ctx_nxt;
	logic [SIZE_BITS-1:0]   cnt_nxt;
	hns_res_t [MAX_RES-1:0] res;
	logic [RES_CNT_W-1:0]   res_n;
	logic                   buf_free;
	logic                   step_en;

	assign step_en      = valid_s1 && buf_free;
	assign stream.ready = !valid_s1 || step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			data_byte_s1  <= stream.data_byte;
			buffer_end_s1 <= stream.buffer_end;
		end
	end

	always_comb begin
		ctx_d = step_en ? ctx_nxt : ctx_q;
		// enabling starts a new recording
		if (cfg_we && cfg_wdata && !rec_q) begin
			ctx_d.sps_seen = 1'b0;
			ctx_d.pps_seen = 1'b0;
			ctx_d.idr_seen = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= '0;
			cnt_q <= '0;
			rec_q <= 1'b0;
		end else begin
			ctx_q <= ctx_d;
			if (step_en)
				cnt_q <= cnt_nxt;
			if (cfg_we)
				rec_q <= cfg_wdata;
		end
	end

	hns_step #(
		.SIZE_BITS(SIZE_BITS)
	) u_step (
		.data_byte     (data_byte_s1),
		.buffer_end    (buffer_end_s1),
		.record_enable (rec_q),
		.ctx_cur       (ctx_q),
		.cnt_cur       (cnt_q),
		.ctx_nxt       (ctx_nxt),
		.cnt_nxt       (cnt_nxt),
		.res           (res),
		.res_n         (res_n)
	);

	hns_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step_en),
		.load_res (res),
		.load_n   (res_n),
		.free     (buf_free),
		.nal      (nal)
	);

endmodule

`default_nettype wire

// ----- design/hns_checker.sv -----
// ----------------------------------------------------------------------------
// hns_checker
// Port-level checks on the result channel of the NAL splitter.
// ----------------------------------------------------------------------------
`default_nettype none

module hns_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  payload_byte,
	input logic        unit_first,
	input logic        unit_last,
	input logic [4:0]  unit_type,
	input logic [1:0]  disposition,
	input logic [23:0] unit_size
);
	import hns_pkg::*;

	// a stalled request holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_byte)
		&& $stable(unit_first) && $stable(unit_last) && $stable(unit_type)
		&& $stable(disposition) && $stable(unit_size))
		else $error("result changed while stalled");

	// size only travels with the last byte
	a_size_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !unit_last |-> unit_size == '0)
		else $error("size on a non-last byte");

	// a one-byte unit reports size one
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unit_first && unit_last |-> unit_size == 24'd1)
		else $error("single-byte unit with wrong size");

	a_disp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> disposition == DISP_FRAME || disposition == DISP_PARAM
		|| disposition == DISP_DROP)
		else $error("bad disposition code");

	// the size of a unit counts its last byte too, so it is nonzero
	a_last_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unit_last |-> unit_size != '0)
		else $error("last byte with zero size");

endmodule

bind h264_annexb_nal_splitter hns_checker u_hns_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (nal.valid),
	.out_ready    (nal.ready),
	.payload_byte (nal.payload_byte),
	.unit_first   (nal.unit_first),
	.unit_last    (nal.unit_last),
	.unit_type    (nal.unit_type),
	.disposition  (nal.disposition),
	.unit_size    (nal.unit_size)
);

`default_nettype wire
